FILE: rtl/rphc_pkg.sv
// Shared types and constants for the relay pulse and hold controller.
package rphc_pkg;

  typedef enum logic [1:0] {
    KIND_AUTO_OPEN   = 2'd0,
    KIND_TOGGLE_ON   = 2'd1,
    KIND_TOGGLE_OFF  = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_t;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  localparam logic REG_PULSE    = 1'b0;
  localparam logic REG_MAX_HOLD = 1'b1;

  localparam logic [15:0] PULSE_TICKS_RST    = 16'd3000;
  localparam logic [15:0] MAX_HOLD_TICKS_RST = 16'd10000;

  typedef struct packed {
    logic        func;
    logic [1:0]  cmd_kind;
    logic [15:0] cmd_tag;
    logic [31:0] hold_request;
  } item_t;

  typedef struct packed {
    logic [15:0] ack_tag;
    logic        ack_failed;
    logic        relay_active;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

FILE: rtl/rphc_chan_if.sv
// Valid/ready channel interfaces for commands and acknowledgements.
interface rphc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  cmd_kind;
  logic [15:0] cmd_tag;
  logic [31:0] hold_request;

  modport source (output valid, func, cmd_kind, cmd_tag, hold_request, input ready);
  modport sink (input valid, func, cmd_kind, cmd_tag, hold_request, output ready);
endinterface

interface rphc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ack_tag;
  logic        ack_failed;
  logic        relay_active;
  logic        last;

  modport source (output valid, ack_tag, ack_failed, relay_active, last, input ready);
  modport sink (input valid, ack_tag, ack_failed, relay_active, last, output ready);
endinterface

FILE: rtl/rphc_outq.sv
// Two-entry result queue that takes up to two results per cycle, as its free space allows.
module rphc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  rphc_pkg::push_t    push,
  output logic [1:0]         space,
  rphc_out_if.source         out_ch
);

  rphc_pkg::result_t q_r [2];
  rphc_pkg::result_t q_nxt [2];
  logic [1:0]        cnt_r, cnt_nxt, cnt_pop;
  logic              pop;

  assign pop     = out_ch.valid && out_ch.ready;
  assign cnt_pop = cnt_r - {1'b0, pop};
  assign space   = 2'd2 - cnt_pop;
  assign cnt_nxt = cnt_pop + push.cnt;

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = q_r[1];
    unique case (cnt_pop)
      2'd0: begin
        q_nxt[0] = push.res0;
        q_nxt[1] = push.res1;
      end
      2'd1: begin
        q_nxt[1] = push.res0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.ack_tag      = q_r[0].ack_tag;
  assign out_ch.ack_failed   = q_r[0].ack_failed;
  assign out_ch.relay_active = q_r[0].relay_active;
  assign out_ch.last         = q_r[0].last;

endmodule

FILE: rtl/relay_pulse_hold_controller.sv
// Relay pulse and hold controller top level: input register, decode, state, config.
// Path: an accepted item waits in the input register until the result queue has space, and its
//   results are then written to the result queue, which drives the output channel.
// Throughput: one item per cycle while results drain; an item with two results needs two
//   output transfers, so a steady run of such items is limited by the output channel.
// Reset: synchronous active-low; relay released, count and tag cleared, default lengths.
module relay_pulse_hold_controller (
  input  logic        clk,
  input  logic        rst_n,
  rphc_in_if.sink     in_ch,
  rphc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [15:0] pulse_r, maxh_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {16'h0, (paddr[2] == rphc_pkg::REG_MAX_HOLD) ? maxh_r : pulse_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= rphc_pkg::PULSE_TICKS_RST;
      maxh_r  <= rphc_pkg::MAX_HOLD_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rphc_pkg::REG_PULSE) begin
        pulse_r <= pwdata[15:0];
      end else begin
        maxh_r <= pwdata[15:0];
      end
    end
  end

  // input register
  rphc_pkg::item_t in_r;
  logic            in_v_r;
  logic            fire;
  logic [1:0]      space;

  assign in_ch.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_r <= '{func: in_ch.func, cmd_kind: in_ch.cmd_kind,
                cmd_tag: in_ch.cmd_tag, hold_request: in_ch.hold_request};
    end
  end

  // decode and state update
  logic              energized_r, energized_nxt;
  logic [15:0]       rem_r, rem_nxt, held_r, held_nxt;
  logic [15:0]       len, dec;
  rphc_pkg::kind_t   kind;
  rphc_pkg::result_t idle_res;
  logic              idle_v;
  rphc_pkg::push_t   pend;
  rphc_pkg::push_t   push;
  logic [1:0]        n;

  assign kind = rphc_pkg::kind_t'(in_r.cmd_kind);
  assign dec  = (rem_r == 16'd0) ? 16'd0 : rem_r - 16'd1;

  always_comb begin
    len = pulse_r;
    if (kind == rphc_pkg::KIND_TOGGLE_ON) begin
      if (in_r.hold_request == 32'd0 || in_r.hold_request > {16'h0, maxh_r}) begin
        len = maxh_r;
      end else begin
        len = in_r.hold_request[15:0];
      end
    end
  end

  // acks always leave the relay released
  always_comb begin
    energized_nxt = energized_r;
    rem_nxt       = rem_r;
    held_nxt      = held_r;
    idle_v        = 1'b0;
    idle_res      = '{ack_tag: in_r.cmd_tag, ack_failed: 1'b0, relay_active: 1'b0,
                      last: 1'b0};
    pend          = '0;
    n             = 2'd0;

    if (in_r.func == rphc_pkg::FUNC_TICK) begin
      if (energized_r) begin
        rem_nxt = dec;
        if (dec == 16'd0) begin
          energized_nxt     = 1'b0;
          n                 = 2'd1;
          pend.res0.ack_tag = held_r;
        end
      end
    end else if (energized_r && kind == rphc_pkg::KIND_TOGGLE_OFF) begin
      energized_nxt     = 1'b0;
      rem_nxt           = 16'd0;
      n                 = 2'd2;
      pend.res0.ack_tag = in_r.cmd_tag;
      pend.res1.ack_tag = held_r;
    end else begin
      energized_nxt = 1'b0;
      rem_nxt       = 16'd0;
      unique case (kind)
        rphc_pkg::KIND_AUTO_OPEN, rphc_pkg::KIND_TOGGLE_ON: begin
          held_nxt = in_r.cmd_tag;
          if (len == 16'd0) begin
            idle_v = 1'b1;
          end else begin
            energized_nxt = 1'b1;
            rem_nxt       = len;
          end
        end
        rphc_pkg::KIND_TOGGLE_OFF: begin
          idle_v = 1'b1;
        end
        rphc_pkg::KIND_UNSUPPORTED: begin
          idle_v              = 1'b1;
          idle_res.ack_failed = 1'b1;
        end
        default: begin
        end
      endcase
      if (energized_r) begin
        pend.res0.ack_tag = held_r;
        pend.res1         = idle_res;
        n                 = idle_v ? 2'd2 : 2'd1;
      end else begin
        pend.res0 = idle_res;
        n         = idle_v ? 2'd1 : 2'd0;
      end
    end

    pend.res0.last = (n == 2'd1);
    pend.res1.last = 1'b1;
    pend.cnt       = n;
  end

  assign fire = in_v_r && (n <= space);
  assign push = '{cnt: fire ? pend.cnt : 2'd0, res0: pend.res0, res1: pend.res1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energized_r <= 1'b0;
      rem_r       <= 16'd0;
      held_r      <= 16'd0;
    end else if (fire) begin
      energized_r <= energized_nxt;
      rem_r       <= rem_nxt;
      held_r      <= held_nxt;
    end
  end

  rphc_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    energized_r |-> (rem_r != 16'd0))
    else $error("relay held with zero count");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !energized_r |-> (rem_r == 16'd0))
    else $error("count left while relay released");

  a_two_acks: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && n == 2'd2) |-> (in_r.func == rphc_pkg::FUNC_CMD && energized_r))
    else $error("two acks without a held command");

  a_space: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (space != 2'd3))
    else $error("result queue overflow");

endmodule

FILE: test/tb_relay_pulse_hold_controller.sv
// Testbench for the relay pulse and hold controller: random and directed items with a scoreboard.
module tb_relay_pulse_hold_controller;

  class ack_scoreboard;
    logic [15:0]       pulse_len;
    logic [15:0]       max_hold;
    bit                energized;
    logic [15:0]       ticks_left;
    logic [15:0]       held_tag;
    rphc_pkg::result_t acks_due[$];
    int                errors;

    function new();
      pulse_len  = rphc_pkg::PULSE_TICKS_RST;
      max_hold   = rphc_pkg::MAX_HOLD_TICKS_RST;
      energized  = 1'b0;
      ticks_left = '0;
      held_tag   = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == rphc_pkg::REG_PULSE) pulse_len = value;
      else max_hold = value;
    endfunction

    function void push_ack(logic [15:0] tag, logic failed);
      rphc_pkg::result_t r;
      r.ack_tag      = tag;
      r.ack_failed   = failed;
      r.relay_active = energized;
      r.last         = 1'b0;
      acks_due.push_back(r);
    endfunction

    function void release_hold();
      energized  = 1'b0;
      ticks_left = '0;
      push_ack(held_tag, 1'b0);
    endfunction

    function void start_cmd(rphc_pkg::kind_t k, logic [15:0] tag, logic [31:0] req);
      logic [15:0] len;
      case (k)
        rphc_pkg::KIND_AUTO_OPEN, rphc_pkg::KIND_TOGGLE_ON: begin
          if (k == rphc_pkg::KIND_AUTO_OPEN) len = pulse_len;
          else if (req == 32'd0 || req > {16'd0, max_hold}) len = max_hold;
          else len = req[15:0];
          held_tag = tag;
          if (len == 16'd0) begin
            release_hold();
          end else begin
            energized  = 1'b1;
            ticks_left = len;
          end
        end
        rphc_pkg::KIND_TOGGLE_OFF: begin
          energized  = 1'b0;
          ticks_left = '0;
          push_ack(tag, 1'b0);
        end
        default: push_ack(tag, 1'b1);
      endcase
    endfunction

    function void note_input(rphc_pkg::item_t it);
      int base;
      base = acks_due.size();
      if (it.func == rphc_pkg::FUNC_TICK) begin
        if (energized) begin
          if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
          if (ticks_left == 16'd0) release_hold();
        end
      end else if (energized) begin
        if (rphc_pkg::kind_t'(it.cmd_kind) == rphc_pkg::KIND_TOGGLE_OFF) begin
          energized  = 1'b0;
          ticks_left = '0;
          push_ack(it.cmd_tag, 1'b0);
          push_ack(held_tag, 1'b0);
        end else begin
          release_hold();
          start_cmd(rphc_pkg::kind_t'(it.cmd_kind), it.cmd_tag, it.hold_request);
        end
      end else begin
        start_cmd(rphc_pkg::kind_t'(it.cmd_kind), it.cmd_tag, it.hold_request);
      end
      if (acks_due.size() > base) acks_due[acks_due.size() - 1].last = 1'b1;
    endfunction

    function void check_result(rphc_pkg::result_t got);
      rphc_pkg::result_t want;
      if (acks_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected ack: expected none, got tag=%h failed=%b active=%b last=%b",
                 $time, got.ack_tag, got.ack_failed, got.relay_active, got.last);
        return;
      end
      want = acks_due.pop_front();
      if (got.ack_tag !== want.ack_tag || got.ack_failed !== want.ack_failed ||
          got.relay_active !== want.relay_active || got.last !== want.last) begin
        errors++;
        $display("%0t: ack mismatch: expected tag=%h failed=%b active=%b last=%b,",
                 $time, want.ack_tag, want.ack_failed, want.relay_active, want.last);
        $display("    got tag=%h failed=%b active=%b last=%b",
                 got.ack_tag, got.ack_failed, got.relay_active, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rphc_in_if  in_ch ();
  rphc_out_if out_ch ();

  relay_pulse_hold_controller u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ack_scoreboard sb = new();
  bit            calm;
  bit            hold_off_req;
  int            gap_pct;
  int            stall_pct;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls and one long hold-off on request
  initial begin
    rphc_pkg::result_t got;
    int                stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.ack_tag      = out_ch.ack_tag;
        got.ack_failed   = out_ch.ack_failed;
        got.relay_active = out_ch.relay_active;
        got.last         = out_ch.last;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 79;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic rphc_pkg::item_t cmd_item(rphc_pkg::kind_t k, logic [15:0] tag,
                                               logic [31:0] req);
    rphc_pkg::item_t it;
    it.func         = rphc_pkg::FUNC_CMD;
    it.cmd_kind     = k;
    it.cmd_tag      = tag;
    it.hold_request = req;
    return it;
  endfunction

  function automatic rphc_pkg::item_t tick_item();
    rphc_pkg::item_t it;
    it.func         = rphc_pkg::FUNC_TICK;
    it.cmd_kind     = 2'($urandom_range(0, 3));
    it.cmd_tag      = 16'($urandom_range(0, 65535));
    it.hold_request = $urandom;
    return it;
  endfunction

  function automatic rphc_pkg::item_t rand_item(int tick_pct);
    rphc_pkg::item_t it;
    if ($urandom_range(0, 99) < tick_pct) return tick_item();
    it.func     = rphc_pkg::FUNC_CMD;
    it.cmd_kind = 2'($urandom_range(0, 3));
    it.cmd_tag  = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: it.hold_request = 32'd0;
      1: it.hold_request = $urandom;
      2: it.hold_request = {16'd0, sb.max_hold};
      3: it.hold_request = {16'd0, sb.max_hold} + 32'd1;
      default: it.hold_request = $urandom_range(1, 40);
    endcase
    return it;
  endfunction

  task automatic send_item(input rphc_pkg::item_t it);
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.cmd_kind     <= it.cmd_kind;
    in_ch.cmd_tag      <= it.cmd_tag;
    in_ch.hold_request <= it.hold_request;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(it);
  endtask

  task automatic idle_in(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_with_gaps(input rphc_pkg::item_t it);
    if (!calm && $urandom_range(0, 99) < gap_pct) idle_in($urandom_range(1, 10));
    send_item(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.acks_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write a register, then read it back in a second transfer
  task automatic write_reg(input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {16'd0, value}) begin
      sb.errors++;
      $display("%0t: register read mismatch: expected %h, got %h",
               $time, {16'd0, value}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] pulse, input logic [15:0] hold);
    wait_drained();
    write_reg(rphc_pkg::REG_PULSE, pulse);
    write_reg(rphc_pkg::REG_MAX_HOLD, hold);
  endtask

  initial begin
    int phase;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= rphc_pkg::FUNC_TICK;
    in_ch.cmd_kind     <= rphc_pkg::KIND_AUTO_OPEN;
    in_ch.cmd_tag      <= '0;
    in_ch.hold_request <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default lengths, commands while idle and during a hold
    send_item(cmd_item(rphc_pkg::KIND_UNSUPPORTED, 16'hFFFF, 32'd0));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_OFF, 16'h0000, 32'hFFFF_FFFF));
    send_item(cmd_item(rphc_pkg::KIND_AUTO_OPEN, 16'd1, 32'd0));
    send_item(tick_item());
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_OFF, 16'd2, 32'd0));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd3, 32'd0));
    send_item(cmd_item(rphc_pkg::KIND_AUTO_OPEN, 16'd4, 32'd5));
    send_item(cmd_item(rphc_pkg::KIND_UNSUPPORTED, 16'd5, 32'd0));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd6, 32'hFFFF_FFFF));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd7, 32'd10001));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd8, 32'd10000));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_OFF, 16'd9, 32'd0));

    // short holds running out
    set_config(16'd2, 16'd3);
    send_item(cmd_item(rphc_pkg::KIND_AUTO_OPEN, 16'd10, 32'd0));
    send_item(tick_item());
    send_item(tick_item());
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd11, 32'd3));
    repeat (3) send_item(tick_item());
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd12, 32'd4));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd13, 32'd1));
    send_item(tick_item());

    // zero length holds
    set_config(16'd0, 16'd0);
    send_item(cmd_item(rphc_pkg::KIND_AUTO_OPEN, 16'd14, 32'd0));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd15, 32'd7));

    set_config(16'hFFFF, 16'hFFFF);
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd16, 32'd65535));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_ON, 16'd17, 32'd0));
    send_item(cmd_item(rphc_pkg::KIND_TOGGLE_OFF, 16'd18, 32'd0));

    // random phases
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(16'd1, 16'd1);
        1: set_config(16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'hFFFF);
        default: set_config(16'($urandom_range(1, 24)), 16'($urandom_range(1, 40)));
      endcase
      gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 25);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 25);
      calm      = (phase == 7);
      if (phase == 4) begin
        hold_off_req = 1'b1;
        repeat (30) send_item(cmd_item(rphc_pkg::kind_t'($urandom_range(2, 3)),
                                       16'($urandom_range(0, 65535)), $urandom));
        wait_drained();
      end
      repeat (205) send_with_gaps(rand_item(60));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.acks_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
